FILE: src/pwfr_pkg.sv
package pwfr_pkg;

  // Default width of the free-running edge timer.
  localparam int TIMER_BITS_DEF = 8;

  // Fixed field widths.
  localparam int CFG_BITS   = 8;
  localparam int WORD_BITS  = 12;
  localparam int DATA_BITS  = 6;
  localparam int DATA_LSB   = WORD_BITS - DATA_BITS;
  localparam int POS_BITS   = 4;
  localparam int CHECK_ROWS_N = 6;

  // Bit position of the first bit of a frame (sent first, stored in the MSB).
  localparam logic [POS_BITS-1:0] BIT_POS_FIRST = POS_BITS'(WORD_BITS - 1);

  // APB register map.
  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS    = 5;
  localparam int REG_IDX_LSB   = 2;
  localparam int REG_IDX_BITS  = PADDR_BITS - REG_IDX_LSB;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_SYNC_MIN = 3'd0,
    REG_SYNC_MAX = 3'd1,
    REG_ZERO_MIN = 3'd2,
    REG_ZERO_MAX = 3'd3,
    REG_ONE_MIN  = 3'd4,
    REG_ONE_MAX  = 3'd5
  } cfg_reg_t;

  // Register reset values in timer ticks.
  localparam logic [CFG_BITS-1:0] SYNC_MIN_RST = 8'd53;
  localparam logic [CFG_BITS-1:0] SYNC_MAX_RST = 8'd68;
  localparam logic [CFG_BITS-1:0] ZERO_MIN_RST = 8'd23;
  localparam logic [CFG_BITS-1:0] ZERO_MAX_RST = 8'd38;
  localparam logic [CFG_BITS-1:0] ONE_MIN_RST  = 8'd7;
  localparam logic [CFG_BITS-1:0] ONE_MAX_RST  = 8'd23;

  // Rows of the parity check matrix; each row must see an even bit count.
  localparam logic [WORD_BITS-1:0] CHECK_ROWS [CHECK_ROWS_N] = '{
    12'h4e0, 12'h690, 12'h348, 12'hd44, 12'ha42, 12'h9c1
  };

  // Interval windows, each with exclusive lower and inclusive upper bound.
  typedef struct packed {
    logic [CFG_BITS-1:0] sync_width_min;
    logic [CFG_BITS-1:0] sync_width_max;
    logic [CFG_BITS-1:0] zero_width_min;
    logic [CFG_BITS-1:0] zero_width_max;
    logic [CFG_BITS-1:0] one_width_min;
    logic [CFG_BITS-1:0] one_width_max;
  } cfg_t;

  // A completed frame handed from the decoder to the result register.
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] word;
  } frame_done_t;

  // True when every check row covers an even number of set bits.
  function automatic logic parity_ok(input logic [WORD_BITS-1:0] word);
    logic ok;
    ok = 1'b1;
    for (int r = 0; r < CHECK_ROWS_N; r++) begin
      ok = ok & ~(^(word & CHECK_ROWS[r]));
    end
    return ok;
  endfunction

endpackage

FILE: src/pwfr_if.sv
// Edge timestamp channel.
interface pwfr_edge_if #(
  parameter int TIMER_BITS = pwfr_pkg::TIMER_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TIMER_BITS-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

// Received frame channel.
interface pwfr_frame_if;
  logic                                valid;
  logic                                ready;
  logic [pwfr_pkg::WORD_BITS-1:0]      code_word;
  logic [pwfr_pkg::DATA_BITS-1:0]      payload;
  logic                                check_ok;

  modport source (output valid, output code_word, output payload, output check_ok,
                  input ready);
  modport sink   (input valid, input code_word, input payload, input check_ok,
                  output ready);
endinterface

FILE: src/pulse_width_frame_receiver_core.sv
// Pulse-width frame receiver. Each edges beat carries the timer value at one
// line edge; the interval since the previous edge (modulo the timer width) is
// classified as sync, zero or one half against the six window registers, and
// every twelfth decoded bit produces one frames beat with the word, its upper
// six data bits and the even-parity check result. One edge is taken per
// clock while the result register has space: a beat is decoded straight
// out of the input register, and a completed frame passes through the
// input register and then the result register on its way to frames. The
// input stalls only while a finished frame waits in the result register and
// the sink holds ready low. Window registers are written over APB and should
// be changed only while no edges are in flight.
module pulse_width_frame_receiver_core #(
  parameter int TIMER_BITS = pwfr_pkg::TIMER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwfr_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [pwfr_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [pwfr_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  pwfr_edge_if.sink                            edges,
  pwfr_frame_if.source                         frames
);

  pwfr_pkg::cfg_t        cfg;
  pwfr_pkg::frame_done_t done;
  logic                  space;

  // Window registers.
  pwfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register, interval classification and frame assembly.
  pwfr_decode #(
    .TIMER_BITS (TIMER_BITS)
  ) u_decode (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .edges (edges),
    .space (space),
    .done  (done)
  );

  // Result register with parity check.
  pwfr_out u_out (
    .clk    (clk),
    .rst    (rst),
    .done   (done),
    .space  (space),
    .frames (frames)
  );

endmodule

FILE: src/pwfr_cfg.sv
module pwfr_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwfr_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [pwfr_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [pwfr_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output pwfr_pkg::cfg_t                       cfg
);

  pwfr_pkg::cfg_reg_t                reg_idx;
  logic [pwfr_pkg::CFG_BITS-1:0]     wdata;

  assign reg_idx = pwfr_pkg::cfg_reg_t'(paddr[pwfr_pkg::PADDR_BITS-1:pwfr_pkg::REG_IDX_LSB]);
  assign wdata   = pwdata[pwfr_pkg::CFG_BITS-1:0];
  assign pready  = 1'b1;

  // Register writes complete in the access phase; unmapped addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_width_min <= pwfr_pkg::SYNC_MIN_RST;
      cfg.sync_width_max <= pwfr_pkg::SYNC_MAX_RST;
      cfg.zero_width_min <= pwfr_pkg::ZERO_MIN_RST;
      cfg.zero_width_max <= pwfr_pkg::ZERO_MAX_RST;
      cfg.one_width_min  <= pwfr_pkg::ONE_MIN_RST;
      cfg.one_width_max  <= pwfr_pkg::ONE_MAX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pwfr_pkg::REG_SYNC_MIN: cfg.sync_width_min <= wdata;
        pwfr_pkg::REG_SYNC_MAX: cfg.sync_width_max <= wdata;
        pwfr_pkg::REG_ZERO_MIN: cfg.zero_width_min <= wdata;
        pwfr_pkg::REG_ZERO_MAX: cfg.zero_width_max <= wdata;
        pwfr_pkg::REG_ONE_MIN:  cfg.one_width_min  <= wdata;
        pwfr_pkg::REG_ONE_MAX:  cfg.one_width_max  <= wdata;
        default: ;
      endcase
    end
  end

  // Read back, zero extended; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pwfr_pkg::REG_SYNC_MIN: prdata = pwfr_pkg::APB_DATA_BITS'(cfg.sync_width_min);
      pwfr_pkg::REG_SYNC_MAX: prdata = pwfr_pkg::APB_DATA_BITS'(cfg.sync_width_max);
      pwfr_pkg::REG_ZERO_MIN: prdata = pwfr_pkg::APB_DATA_BITS'(cfg.zero_width_min);
      pwfr_pkg::REG_ZERO_MAX: prdata = pwfr_pkg::APB_DATA_BITS'(cfg.zero_width_max);
      pwfr_pkg::REG_ONE_MIN:  prdata = pwfr_pkg::APB_DATA_BITS'(cfg.one_width_min);
      pwfr_pkg::REG_ONE_MAX:  prdata = pwfr_pkg::APB_DATA_BITS'(cfg.one_width_max);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: src/pwfr_decode.sv
module pwfr_decode #(
  parameter int TIMER_BITS = pwfr_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pwfr_pkg::cfg_t        cfg,
  pwfr_edge_if.sink             edges,
  input  logic                  space,
  output pwfr_pkg::frame_done_t done
);

  localparam int WB = pwfr_pkg::WORD_BITS;
  localparam int PB = pwfr_pkg::POS_BITS;

  // Input register.
  logic                  s1_valid;
  logic [TIMER_BITS-1:0] s1_time;

  // Receiver state.
  logic [TIMER_BITS-1:0] previous_edge_time;
  logic                  in_frame;
  logic [PB-1:0]         bit_position;
  logic                  one_half_seen;
  logic [WB-1:0]         frame_bits;

  logic                  in_frame_next;
  logic [PB-1:0]         bit_position_next;
  logic                  one_half_seen_next;
  logic [WB-1:0]         frame_bits_next;

  logic                  advance;
  logic [TIMER_BITS-1:0] width;
  logic                  is_sync;
  logic                  is_zero;
  logic                  is_one;
  logic                  bit_done;
  logic                  bit_val;
  logic [WB-1:0]         bit_mask;

  // The held beat is decoded whenever the result register can take a frame.
  assign advance     = s1_valid && space;
  assign edges.ready = !s1_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      previous_edge_time <= '0;
      in_frame           <= 1'b0;
      bit_position       <= pwfr_pkg::BIT_POS_FIRST;
      one_half_seen      <= 1'b0;
      frame_bits         <= '0;
    end else begin
      if (edges.ready) begin
        s1_valid <= edges.valid;
      end
      if (advance) begin
        previous_edge_time <= s1_time;
        in_frame           <= in_frame_next;
        bit_position       <= bit_position_next;
        one_half_seen      <= one_half_seen_next;
        frame_bits         <= frame_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edges.valid && edges.ready) begin
      s1_time <= edges.edge_time;
    end
  end

  // Interval since the previous edge wraps with the timer.
  assign width   = s1_time - previous_edge_time;
  assign is_sync = (width > TIMER_BITS'(cfg.sync_width_min)) &&
                   (width <= TIMER_BITS'(cfg.sync_width_max));
  assign is_zero = (width > TIMER_BITS'(cfg.zero_width_min)) &&
                   (width <= TIMER_BITS'(cfg.zero_width_max));
  assign is_one  = (width > TIMER_BITS'(cfg.one_width_min)) &&
                   (width <= TIMER_BITS'(cfg.one_width_max));
  assign bit_mask = WB'(1) << bit_position;

  // Classify the interval and update the frame; sync wins over zero over one.
  always_comb begin
    in_frame_next      = in_frame;
    bit_position_next  = bit_position;
    one_half_seen_next = one_half_seen;
    frame_bits_next    = frame_bits;
    bit_done           = 1'b0;
    bit_val            = 1'b0;
    done               = '0;

    if (is_sync) begin
      in_frame_next      = 1'b1;
      bit_position_next  = pwfr_pkg::BIT_POS_FIRST;
      one_half_seen_next = 1'b0;
      frame_bits_next    = '0;
    end else if (is_zero) begin
      if (in_frame && !one_half_seen) begin
        bit_done = 1'b1;
      end else begin
        in_frame_next     = 1'b0;
        bit_position_next = pwfr_pkg::BIT_POS_FIRST;
        frame_bits_next   = '0;
      end
    end else if (is_one) begin
      if (in_frame) begin
        if (one_half_seen) begin
          one_half_seen_next = 1'b0;
          bit_done           = 1'b1;
          bit_val            = 1'b1;
        end else begin
          one_half_seen_next = 1'b1;
        end
      end else begin
        in_frame_next     = 1'b0;
        bit_position_next = pwfr_pkg::BIT_POS_FIRST;
        frame_bits_next   = '0;
      end
    end else begin
      in_frame_next      = 1'b0;
      bit_position_next  = pwfr_pkg::BIT_POS_FIRST;
      one_half_seen_next = 1'b0;
      frame_bits_next    = '0;
    end

    // Store the bit; the last position closes the frame.
    if (bit_done) begin
      frame_bits_next = bit_val ? (frame_bits | bit_mask) : (frame_bits & ~bit_mask);
      if (bit_position != '0) begin
        bit_position_next = bit_position - PB'(1);
      end else begin
        done.valid        = advance;
        done.word         = frame_bits_next;
        in_frame_next     = 1'b0;
        bit_position_next = pwfr_pkg::BIT_POS_FIRST;
        frame_bits_next   = '0;
      end
    end
  end

  // The write position never leaves the 12-bit word.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= pwfr_pkg::BIT_POS_FIRST)
    else $error("bit position out of range");

  // Outside a frame nothing has been collected.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (frame_bits == '0 && bit_position == pwfr_pkg::BIT_POS_FIRST))
    else $error("stale frame state outside a frame");

  // A frame completes only from inside a frame at the last position, and ends it.
  a_done_ctx: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> (in_frame && bit_position == '0) ##1 (!in_frame && !one_half_seen))
    else $error("frame completed out of context");

endmodule

FILE: src/pwfr_out.sv
module pwfr_out (
  input  logic                  clk,
  input  logic                  rst,
  input  pwfr_pkg::frame_done_t done,
  output logic                  space,
  pwfr_frame_if.source          frames
);

  logic                                 valid;
  logic [pwfr_pkg::WORD_BITS-1:0]       code_word;
  logic [pwfr_pkg::DATA_BITS-1:0]       payload;
  logic                                 check_ok;

  // The result register can take a frame when empty or being drained this cycle.
  assign space = !valid || frames.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (done.valid) begin
      valid <= 1'b1;
    end else if (frames.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload and parity result are captured with the word.
  always_ff @(posedge clk) begin
    if (done.valid) begin
      code_word <= done.word;
      payload   <= done.word[pwfr_pkg::WORD_BITS-1:pwfr_pkg::DATA_LSB];
      check_ok  <= pwfr_pkg::parity_ok(done.word);
    end
  end

  assign frames.valid     = valid;
  assign frames.code_word = code_word;
  assign frames.payload   = payload;
  assign frames.check_ok  = check_ok;

  // A new frame never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> (!valid || frames.ready))
    else $error("result register overwritten");

endmodule

FILE: tb/sv/tb_pulse_width_frame_receiver_core.sv
`timescale 1ns / 100ps

module tb_pulse_width_frame_receiver_core;

  localparam int TIMER_W         = pwfr_pkg::TIMER_BITS_DEF;
  localparam int NUM_WINDOW_REGS = 6;
  localparam int DRAIN_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 300000;

  // One expected or observed frames beat.
  typedef struct packed {
    logic [pwfr_pkg::WORD_BITS-1:0] code_word;
    logic [pwfr_pkg::DATA_BITS-1:0] payload;
    logic                           check_ok;
  } frame_beat_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pwfr_pkg::PADDR_BITS-1:0]    paddr;
  logic [pwfr_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [pwfr_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  pwfr_edge_if #(.TIMER_BITS(TIMER_W)) edge_ch ();
  pwfr_frame_if frame_ch ();

  pulse_width_frame_receiver_core #(.TIMER_BITS(TIMER_W)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .edges   (edge_ch),
    .frames  (frame_ch)
  );

  // Window settings as the decoder model sees them.
  pwfr_pkg::cfg_t win = '{
    sync_width_min: pwfr_pkg::SYNC_MIN_RST, sync_width_max: pwfr_pkg::SYNC_MAX_RST,
    zero_width_min: pwfr_pkg::ZERO_MIN_RST, zero_width_max: pwfr_pkg::ZERO_MAX_RST,
    one_width_min:  pwfr_pkg::ONE_MIN_RST,  one_width_max:  pwfr_pkg::ONE_MAX_RST
  };

  // Decoder model state.
  logic [TIMER_W-1:0]             last_time    = '0;
  logic                           framing      = 1'b0;
  logic [pwfr_pkg::POS_BITS-1:0]  bit_pos      = pwfr_pkg::BIT_POS_FIRST;
  logic                           half_pending = 1'b0;
  logic [pwfr_pkg::WORD_BITS-1:0] word_acc     = '0;

  frame_beat_t pending_frames[$];

  // Stimulus side: timer value of the last edge sent, and burst pacing.
  logic [TIMER_W-1:0] tx_time = '0;
  int burst_left     = 0;
  int edges_sent     = 0;
  int frames_seen    = 0;
  int frames_clean   = 0;
  int windows_loaded = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames outstanding", cycle_count,
               pending_frames.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // True when every check row covers an even number of set bits.
  function automatic logic even_checks(input logic [pwfr_pkg::WORD_BITS-1:0] word);
    logic ok;
    ok = 1'b1;
    for (int r = 0; r < pwfr_pkg::CHECK_ROWS_N; r++) begin
      if (^(word & pwfr_pkg::CHECK_ROWS[r])) ok = 1'b0;
    end
    return ok;
  endfunction

  // Each row has exactly one of the low six bits, so a row's parity bit can be
  // chosen from the data field alone.
  function automatic logic [pwfr_pkg::WORD_BITS-1:0] make_codeword(
      input logic [pwfr_pkg::DATA_BITS-1:0] data);
    logic [pwfr_pkg::WORD_BITS-1:0] w;
    w = {data, {pwfr_pkg::DATA_LSB{1'b0}}};
    for (int r = 0; r < pwfr_pkg::CHECK_ROWS_N; r++) begin
      w[pwfr_pkg::DATA_LSB-1-r] = ^({data, {pwfr_pkg::DATA_LSB{1'b0}}} &
                                    pwfr_pkg::CHECK_ROWS[r]);
    end
    return w;
  endfunction

  function automatic logic in_win(input logic [pwfr_pkg::CFG_BITS-1:0] w,
                                  input logic [pwfr_pkg::CFG_BITS-1:0] lo,
                                  input logic [pwfr_pkg::CFG_BITS-1:0] hi);
    return (w > lo) && (w <= hi);
  endfunction

  function automatic void drop_frame();
    framing  = 1'b0;
    bit_pos  = pwfr_pkg::BIT_POS_FIRST;
    word_acc = '0;
  endfunction

  // Decode one accepted edge; a twelfth bit queues the expected frame.
  function automatic void decode_edge(input logic [TIMER_W-1:0] t);
    logic [TIMER_W-1:0] w;
    logic               bit_done;
    logic               bit_val;
    frame_beat_t        exp_beat;
    w         = t - last_time;
    last_time = t;
    bit_done  = 1'b0;
    bit_val   = 1'b0;
    if (in_win(w, win.sync_width_min, win.sync_width_max)) begin
      framing      = 1'b1;
      bit_pos      = pwfr_pkg::BIT_POS_FIRST;
      half_pending = 1'b0;
      word_acc     = '0;
    end else if (in_win(w, win.zero_width_min, win.zero_width_max)) begin
      if (framing && !half_pending) bit_done = 1'b1;
      else drop_frame();
    end else if (in_win(w, win.one_width_min, win.one_width_max)) begin
      if (!framing) begin
        drop_frame();
      end else if (half_pending) begin
        half_pending = 1'b0;
        bit_done     = 1'b1;
        bit_val      = 1'b1;
      end else begin
        half_pending = 1'b1;
      end
    end else begin
      drop_frame();
      half_pending = 1'b0;
    end
    if (bit_done) begin
      word_acc[bit_pos] = bit_val;
      if (bit_pos != '0) begin
        bit_pos = bit_pos - 1'b1;
      end else begin
        exp_beat.code_word = word_acc;
        exp_beat.payload   = word_acc[pwfr_pkg::WORD_BITS-1:pwfr_pkg::DATA_LSB];
        exp_beat.check_ok  = even_checks(word_acc);
        pending_frames.push_back(exp_beat);
        drop_frame();
      end
    end
  endfunction

  // Frames sink: stalls on a random pattern that is redrawn after a random
  // span and checks each accepted beat against the oldest expectation.
  task automatic check_frame_beat();
    frame_beat_t got;
    frame_beat_t want;
    got.code_word = frame_ch.code_word;
    got.payload   = frame_ch.payload;
    got.check_ok  = frame_ch.check_ok;
    frames_seen++;
    if (pending_frames.size() == 0) begin
      report_mismatch("frames beat with none expected, code_word", 32'(got.code_word), '0);
    end else begin
      want = pending_frames.pop_front();
      if (want.check_ok) frames_clean++;
      if (got.code_word !== want.code_word)
        report_mismatch("code_word", 32'(got.code_word), 32'(want.code_word));
      if (got.payload !== want.payload)
        report_mismatch("payload", 32'(got.payload), 32'(want.payload));
      if (got.check_ok !== want.check_ok)
        report_mismatch("check_ok", 32'(got.check_ok), 32'(want.check_ok));
    end
  endtask

  initial begin : frame_sink
    int   rx_mode;
    int   rx_span;
    logic rdy;
    rx_mode = 0;
    rx_span = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) check_frame_beat();
      if (rx_span == 0) begin
        rx_mode = $urandom_range(3, 0);
        rx_span = $urandom_range(80, 20);
      end
      rx_span--;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(1, 0));
        2: rdy = ($urandom_range(9, 0) == 0);
        default: rdy = ($urandom_range(9, 0) != 0);
      endcase
      frame_ch.ready <= rdy;
    end
  end

  // Send one edges beat; bursts of random length are separated by random gaps.
  task automatic send_edge(input logic [TIMER_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(99, 0) < 30) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        edge_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(32, 1);
    end
    edge_ch.valid     <= 1'b1;
    edge_ch.edge_time <= t;
    @(posedge clk);
    while (edge_ch.ready !== 1'b1) @(posedge clk);
    decode_edge(t);
    tx_time = t;
    burst_left--;
    edges_sent++;
  endtask

  task automatic send_width(input logic [TIMER_W-1:0] w);
    send_edge(tx_time + w);
  endtask

  // A width inside the window, or any width when the window is empty.
  function automatic logic [TIMER_W-1:0] width_in(input logic [pwfr_pkg::CFG_BITS-1:0] lo,
                                                  input logic [pwfr_pkg::CFG_BITS-1:0] hi);
    if (hi > lo) return TIMER_W'($urandom_range(int'(hi), int'(lo) + 1));
    return TIMER_W'($urandom_range(255, 0));
  endfunction

  task automatic send_sync();
    send_width(width_in(win.sync_width_min, win.sync_width_max));
  endtask

  task automatic send_half();
    send_width(width_in(win.one_width_min, win.one_width_max));
  endtask

  task automatic send_zero();
    send_width(width_in(win.zero_width_min, win.zero_width_max));
  endtask

  task automatic send_bit(input logic b);
    if (b) begin
      send_half();
      send_half();
    end else begin
      send_zero();
    end
  endtask

  task automatic send_frame(input logic [pwfr_pkg::WORD_BITS-1:0] word);
    send_sync();
    for (int i = pwfr_pkg::WORD_BITS - 1; i >= 0; i--) send_bit(word[i]);
  endtask

  // Clean codewords, codewords with one bit flipped, and arbitrary words.
  function automatic logic [pwfr_pkg::WORD_BITS-1:0] pick_word();
    int                             roll;
    int                             flip;
    logic [pwfr_pkg::WORD_BITS-1:0] w;
    roll = $urandom_range(99, 0);
    flip = $urandom_range(pwfr_pkg::WORD_BITS - 1, 0);
    w    = make_codeword(pwfr_pkg::DATA_BITS'($urandom));
    if (roll < 15) w[flip] = ~w[flip];
    else if (roll >= 50) w = pwfr_pkg::WORD_BITS'($urandom);
    return w;
  endfunction

  // Lower valid, let every expected frame arrive and the pipeline empty.
  task automatic wait_idle();
    edge_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [pwfr_pkg::CFG_BITS-1:0] win_value(
      input logic [pwfr_pkg::REG_IDX_BITS-1:0] idx);
    case (idx)
      pwfr_pkg::REG_SYNC_MIN: return win.sync_width_min;
      pwfr_pkg::REG_SYNC_MAX: return win.sync_width_max;
      pwfr_pkg::REG_ZERO_MIN: return win.zero_width_min;
      pwfr_pkg::REG_ZERO_MAX: return win.zero_width_max;
      pwfr_pkg::REG_ONE_MIN:  return win.one_width_min;
      pwfr_pkg::REG_ONE_MAX:  return win.one_width_max;
      default:                return '0;
    endcase
  endfunction

  // APB write: setup, access, then the bus returns to idle.
  task automatic apb_write(input logic [pwfr_pkg::REG_IDX_BITS-1:0] idx,
                           input logic [pwfr_pkg::CFG_BITS-1:0] v);
    logic [pwfr_pkg::APB_DATA_BITS-1:0] d;
    d = $urandom;
    d[pwfr_pkg::CFG_BITS-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pwfr_pkg::PADDR_BITS'(idx) << pwfr_pkg::REG_IDX_LSB;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      pwfr_pkg::REG_SYNC_MIN: win.sync_width_min = v;
      pwfr_pkg::REG_SYNC_MAX: win.sync_width_max = v;
      pwfr_pkg::REG_ZERO_MIN: win.zero_width_min = v;
      pwfr_pkg::REG_ZERO_MAX: win.zero_width_max = v;
      pwfr_pkg::REG_ONE_MIN:  win.one_width_min  = v;
      pwfr_pkg::REG_ONE_MAX:  win.one_width_max  = v;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [pwfr_pkg::REG_IDX_BITS-1:0] idx,
                          output logic [pwfr_pkg::APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= pwfr_pkg::PADDR_BITS'(idx) << pwfr_pkg::REG_IDX_LSB;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read every window register back and compare with the shadow copy.
  task automatic check_windows();
    logic [pwfr_pkg::APB_DATA_BITS-1:0] rd;
    for (int i = 0; i < NUM_WINDOW_REGS; i++) begin
      apb_read(pwfr_pkg::REG_IDX_BITS'(i), rd);
      if (rd !== pwfr_pkg::APB_DATA_BITS'(win_value(pwfr_pkg::REG_IDX_BITS'(i))))
        report_mismatch($sformatf("window register %0d read", i), rd,
                        pwfr_pkg::APB_DATA_BITS'(win_value(pwfr_pkg::REG_IDX_BITS'(i))));
    end
  endtask

  task automatic load_windows(input pwfr_pkg::cfg_t c);
    wait_idle();
    apb_write(pwfr_pkg::REG_SYNC_MIN, c.sync_width_min);
    apb_write(pwfr_pkg::REG_SYNC_MAX, c.sync_width_max);
    apb_write(pwfr_pkg::REG_ZERO_MIN, c.zero_width_min);
    apb_write(pwfr_pkg::REG_ZERO_MAX, c.zero_width_max);
    apb_write(pwfr_pkg::REG_ONE_MIN,  c.one_width_min);
    apb_write(pwfr_pkg::REG_ONE_MAX,  c.one_width_max);
    check_windows();
    windows_loaded++;
  endtask

  // Mostly well-formed frames, the rest broken sequences and line noise.
  task automatic test_random_frames(input int n);
    int first;
    int roll;
    int k;
    first = edges_sent;
    while (edges_sent - first < n) begin
      roll = $urandom_range(99, 0);
      k    = $urandom_range(pwfr_pkg::WORD_BITS - 1, 0);
      if (roll < 70) begin
        send_frame(pick_word());
      end else if (roll < 92) begin
        send_sync();
        repeat (k) send_bit(1'($urandom_range(1, 0)));
        if (roll < 85) begin
          // Truncated frame, or a zero arriving with a one half pending.
          if (roll >= 78) begin
            send_half();
            send_zero();
          end
        end else begin
          send_width(TIMER_W'($urandom_range(255, 0)));
        end
      end else begin
        repeat ($urandom_range(4, 1)) send_width(TIMER_W'($urandom_range(255, 0)));
      end
    end
  endtask

  // Reset windows, both timer extremes, aborts of every kind, one full frame.
  task automatic test_directed_edges();
    check_windows();
    // Same timer value as after reset: a zero-length interval.
    send_edge('0);
    // A zero bit and a one half with no frame open.
    send_zero();
    send_half();
    // A zero after a one half aborts the frame.
    send_sync();
    send_bit(1'b0);
    send_bit(1'b0);
    send_bit(1'b0);
    send_half();
    send_zero();
    // A sync inside a frame restarts it; the next frame completes cleanly.
    send_sync();
    send_bit(1'b0);
    send_frame(make_codeword(6'h20));
    // Largest timer value, then the widest interval.
    send_edge('1);
    send_width('1);
  endtask

  // Ordered, separated windows of random size and placement.
  task automatic test_spread_windows();
    pwfr_pkg::cfg_t c;
    repeat (2) begin
      c.one_width_min  = pwfr_pkg::CFG_BITS'($urandom_range(30, 0));
      c.one_width_max  = c.one_width_min + pwfr_pkg::CFG_BITS'($urandom_range(25, 2));
      c.zero_width_min = c.one_width_max + pwfr_pkg::CFG_BITS'($urandom_range(10, 0));
      c.zero_width_max = c.zero_width_min + pwfr_pkg::CFG_BITS'($urandom_range(30, 2));
      c.sync_width_min = c.zero_width_max + pwfr_pkg::CFG_BITS'($urandom_range(20, 0));
      c.sync_width_max = c.sync_width_min + pwfr_pkg::CFG_BITS'($urandom_range(40, 2));
      load_windows(c);
      test_random_frames(100);
    end
  endtask

  // Overlaps are resolved in the order sync, zero, one.
  task automatic test_overlapping_windows();
    load_windows('{sync_width_min: 8'd20, sync_width_max: 8'd45,
                   zero_width_min: 8'd30, zero_width_max: 8'd60,
                   one_width_min:  8'd10, one_width_max:  8'd35});
    test_random_frames(80);
  endtask

  // Bounds at 0 and 255, all windows empty, inverted bounds, sync everywhere.
  task automatic test_extreme_windows();
    load_windows('{sync_width_min: 8'd100, sync_width_max: 8'd255,
                   zero_width_min: 8'd10,  zero_width_max: 8'd100,
                   one_width_min:  8'd0,   one_width_max:  8'd10});
    test_random_frames(60);
    load_windows('0);
    test_random_frames(20);
    load_windows('{sync_width_min: 8'd255, sync_width_max: 8'd0,
                   zero_width_min: 8'd0,   zero_width_max: 8'd255,
                   one_width_min:  8'd0,   one_width_max:  8'd255});
    test_random_frames(20);
    load_windows('{sync_width_min: 8'd0,   sync_width_max: 8'd255,
                   zero_width_min: 8'd255, zero_width_max: 8'd255,
                   one_width_min:  8'd128, one_width_max:  8'd0});
    test_random_frames(20);
  endtask

  // Writes past the last window register leave every register unchanged.
  task automatic test_unmapped_writes();
    wait_idle();
    for (int i = NUM_WINDOW_REGS; i < (1 << pwfr_pkg::REG_IDX_BITS); i++)
      apb_write(pwfr_pkg::REG_IDX_BITS'(i), pwfr_pkg::CFG_BITS'($urandom));
    check_windows();
  endtask

  task automatic test_restored_defaults();
    load_windows('{sync_width_min: pwfr_pkg::SYNC_MIN_RST,
                   sync_width_max: pwfr_pkg::SYNC_MAX_RST,
                   zero_width_min: pwfr_pkg::ZERO_MIN_RST,
                   zero_width_max: pwfr_pkg::ZERO_MAX_RST,
                   one_width_min:  pwfr_pkg::ONE_MIN_RST,
                   one_width_max:  pwfr_pkg::ONE_MAX_RST});
    test_random_frames(100);
  endtask

  // Main sequence.
  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    edge_ch.valid     <= 1'b0;
    edge_ch.edge_time <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_random_frames(120);
    test_spread_windows();
    test_overlapping_windows();
    test_extreme_windows();
    test_unmapped_writes();
    test_restored_defaults();
    wait_idle();

    $display("Ran %0d edge beats under %0d reloaded window settings.", edges_sent,
             windows_loaded);
    $display("Checked %0d frame beats, %0d of them parity-clean; %0d mismatches.",
             frames_seen, frames_clean, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
